// File: hw/rtl/lmsf_pkg.sv
// Shared types, widths and register codes of the adaptive LMS FIR filter.
package lmsf_pkg;

   localparam int MAX_TAPS    = 64;
   localparam int ADDR_W      = $clog2(MAX_TAPS);
   localparam int TAP_COUNT_W = 7;
   localparam int CNT_W       = (ADDR_W + 1 > TAP_COUNT_W) ? ADDR_W + 1 : TAP_COUNT_W;
   localparam int SAMPLE_W    = 16;
   localparam int WEIGHT_W    = 16;
   localparam int ERROR_W     = 32;
   localparam int OUT_W       = 32;
   localparam int PROD_W      = 32;
   localparam int UPROD_W     = 48;
   localparam int SHIFT_W     = 5;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;
   localparam int REG_SEL_W   = 2;

   localparam logic [REG_SEL_W-1:0] REG_TAP_COUNT    = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_OUTPUT_SHIFT = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_UPDATE_SHIFT = 2'd2;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET    = 7'd16;
   localparam logic [SHIFT_W-1:0]     OUTPUT_SHIFT_RESET = 5'd15;
   localparam logic [SHIFT_W-1:0]     UPDATE_SHIFT_RESET = 5'd15;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef struct packed {
      logic [TAP_COUNT_W-1:0] tap_count;
      logic [SHIFT_W-1:0]     output_shift;
      logic [SHIFT_W-1:0]     update_shift;
   } cfg_type;

   // One tap read issued to both memories.
   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      addr_type addr;
   } issue_type;

   // Write-back of one updated weight.
   typedef struct packed {
      logic                en;
      addr_type            addr;
      logic [WEIGHT_W-1:0] data;
   } wwr_type;

endpackage

// File: hw/rtl/lmsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lmsf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lmsf_csr.sv
// APB-style configuration registers of the adaptive LMS FIR filter.
module lmsf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lmsf_pkg::PADDR_W-1:0]  paddr,
   input  logic [lmsf_pkg::PDATA_W-1:0]  pwdata,
   output logic [lmsf_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output lmsf_pkg::cfg_type             cfg
);

   lmsf_pkg::cfg_type                  cfg_ff;
   lmsf_pkg::cfg_type                  cfg_in;
   logic [lmsf_pkg::REG_SEL_W-1:0]     sel;
   logic                               wr_stb;

   assign sel    = paddr[lmsf_pkg::PADDR_W-1:2];
   assign wr_stb = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (sel)
            lmsf_pkg::REG_TAP_COUNT: begin
               cfg_in.tap_count = pwdata[lmsf_pkg::TAP_COUNT_W-1:0];
            end
            lmsf_pkg::REG_OUTPUT_SHIFT: begin
               cfg_in.output_shift = pwdata[lmsf_pkg::SHIFT_W-1:0];
            end
            lmsf_pkg::REG_UPDATE_SHIFT: begin
               cfg_in.update_shift = pwdata[lmsf_pkg::SHIFT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_count    <= lmsf_pkg::TAP_COUNT_RESET;
         cfg_ff.output_shift <= lmsf_pkg::OUTPUT_SHIFT_RESET;
         cfg_ff.update_shift <= lmsf_pkg::UPDATE_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (sel)
         lmsf_pkg::REG_TAP_COUNT: begin
            prdata = lmsf_pkg::PDATA_W'(cfg_ff.tap_count);
         end
         lmsf_pkg::REG_OUTPUT_SHIFT: begin
            prdata = lmsf_pkg::PDATA_W'(cfg_ff.output_shift);
         end
         lmsf_pkg::REG_UPDATE_SHIFT: begin
            prdata = lmsf_pkg::PDATA_W'(cfg_ff.update_shift);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// File: hw/rtl/lmsf_mac.sv
// Per-tap multiply, shift and accumulate, and weight update write-back.
module lmsf_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  lmsf_pkg::issue_type                 issue,
   input  logic [lmsf_pkg::WEIGHT_W-1:0]       weight_rd,
   input  logic [lmsf_pkg::SAMPLE_W-1:0]       sample_rd,
   input  logic [lmsf_pkg::ERROR_W-1:0]        error_val,
   input  logic                                adapt,
   input  logic [lmsf_pkg::SHIFT_W-1:0]        output_shift,
   input  logic [lmsf_pkg::SHIFT_W-1:0]        update_shift,
   output lmsf_pkg::wwr_type                   wwr,
   output logic                                done,
   output logic [lmsf_pkg::OUT_W-1:0]          acc
);

   // Stage one lines up with the memory read data, stage two holds products.
   lmsf_pkg::issue_type                   s1_ff;
   lmsf_pkg::issue_type                   s2_ff;
   logic signed [lmsf_pkg::PROD_W-1:0]    prod_w_ff;
   logic signed [lmsf_pkg::PROD_W-1:0]    prod_w_in;
   logic signed [lmsf_pkg::UPROD_W-1:0]   prod_e_ff;
   logic signed [lmsf_pkg::UPROD_W-1:0]   prod_e_in;
   logic [lmsf_pkg::WEIGHT_W-1:0]         w_old_ff;
   logic [lmsf_pkg::OUT_W-1:0]            acc_ff;
   logic [lmsf_pkg::OUT_W-1:0]            acc_in;
   logic                                  done_ff;
   logic signed [lmsf_pkg::PROD_W-1:0]    prod_w_sh;
   logic signed [lmsf_pkg::UPROD_W-1:0]   prod_e_sh;

   assign prod_w_in = $signed(weight_rd) * $signed(sample_rd);
   assign prod_e_in = $signed(error_val) * $signed(sample_rd);

   assign prod_w_sh = prod_w_ff >>> output_shift;
   assign prod_e_sh = prod_e_ff >>> update_shift;

   always_comb begin
      acc_in = acc_ff;
      if (s2_ff.valid) begin
         acc_in = (s2_ff.first ? '0 : acc_ff) + $unsigned(prod_w_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_ff.valid <= issue.valid;
         s2_ff.valid <= s1_ff.valid;
         done_ff     <= s2_ff.valid & s2_ff.last;
      end
      s1_ff.first <= issue.first;
      s1_ff.last  <= issue.last;
      s1_ff.addr  <= issue.addr;
      s2_ff.first <= s1_ff.first;
      s2_ff.last  <= s1_ff.last;
      s2_ff.addr  <= s1_ff.addr;
      prod_w_ff   <= prod_w_in;
      prod_e_ff   <= prod_e_in;
      w_old_ff    <= weight_rd;
      acc_ff      <= acc_in;
   end

   assign wwr.en   = s2_ff.valid & adapt;
   assign wwr.addr = s2_ff.addr;
   assign wwr.data = w_old_ff + prod_e_sh[lmsf_pkg::WEIGHT_W-1:0];
   assign done     = done_ff;
   assign acc      = acc_ff;

endmodule

// File: hw/rtl/lms_adaptive_fir_unit.sv
// Top level of the adaptive LMS FIR filter: sequencer, memories and ports.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid / req_ready  req_sample_in, req_error_in, req_adapt
//   rsp       out        rsp_valid / rsp_ready  rsp_filter_out
//   csr       in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One tap is processed per cycle: req_ready stays low while a transaction runs
// its active taps, drains the MAC pipeline and moves its result to the output
// register; the single read port of each memory sets the tap rate. After reset
// a clearing pass zeroes all MAX_TAPS (64) entries of both memories, and no
// transaction is accepted until it ends. A new transaction is accepted while a
// result waits in the output register; its own result waits until then.
module lms_adaptive_fir_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [lmsf_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic signed [lmsf_pkg::ERROR_W-1:0]  req_error_in,
   input  logic                                 req_adapt,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lmsf_pkg::OUT_W-1:0]    rsp_filter_out,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lmsf_pkg::PADDR_W-1:0]         paddr,
   input  logic [lmsf_pkg::PDATA_W-1:0]         pwdata,
   output logic [lmsf_pkg::PDATA_W-1:0]         prdata,
   output logic                                 pready
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   lmsf_pkg::cfg_type                cfg;
   logic [2:0]                       state_ff;
   logic [2:0]                       state_in;
   lmsf_pkg::addr_type               clr_cnt_ff;
   lmsf_pkg::addr_type               clr_cnt_in;
   lmsf_pkg::addr_type               newest_ff;
   lmsf_pkg::addr_type               newest_in;
   lmsf_pkg::addr_type               tap_ff;
   lmsf_pkg::addr_type               tap_in;
   lmsf_pkg::addr_type               idx_ff;
   lmsf_pkg::addr_type               idx_in;
   logic [lmsf_pkg::ERROR_W-1:0]     error_ff;
   logic                             adapt_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [lmsf_pkg::OUT_W-1:0]       rsp_data_ff;
   lmsf_pkg::cnt_type                taps;
   lmsf_pkg::cnt_type                tap_count_ext;
   lmsf_pkg::cnt_type                idx_next;
   lmsf_pkg::addr_type               last_tap;
   logic                             accept;
   logic                             out_free;
   lmsf_pkg::issue_type              issue;
   lmsf_pkg::wwr_type                wwr;
   logic                             mac_done;
   logic [lmsf_pkg::OUT_W-1:0]       mac_acc;
   logic                             ring_we;
   lmsf_pkg::addr_type               ring_waddr;
   logic [lmsf_pkg::SAMPLE_W-1:0]    ring_wdata;
   logic [lmsf_pkg::SAMPLE_W-1:0]    ring_rdata;
   logic                             wgt_we;
   lmsf_pkg::addr_type               wgt_waddr;
   logic [lmsf_pkg::WEIGHT_W-1:0]    wgt_wdata;
   logic [lmsf_pkg::WEIGHT_W-1:0]    wgt_rdata;

   lmsf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Active tap count: zero acts as one, anything above the ring size is clamped.
   assign tap_count_ext = lmsf_pkg::cnt_type'(cfg.tap_count);
   always_comb begin
      if (tap_count_ext == '0) begin
         taps = lmsf_pkg::cnt_type'(1);
      end else if (tap_count_ext > lmsf_pkg::cnt_type'(lmsf_pkg::MAX_TAPS)) begin
         taps = lmsf_pkg::cnt_type'(lmsf_pkg::MAX_TAPS);
      end else begin
         taps = tap_count_ext;
      end
   end
   assign last_tap = lmsf_pkg::addr_type'(taps - lmsf_pkg::cnt_type'(1));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // A stale position left over from a larger tap count restarts at the top.
   assign newest_in = ((newest_ff == '0) || (lmsf_pkg::cnt_type'(newest_ff) >= taps))
                      ? last_tap : newest_ff - lmsf_pkg::addr_type'(1);

   assign idx_next = lmsf_pkg::cnt_type'(idx_ff) + lmsf_pkg::cnt_type'(1);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      tap_in       = tap_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      issue.valid  = 1'b0;
      issue.first  = (tap_ff == '0);
      issue.last   = (tap_ff == last_tap);
      issue.addr   = tap_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + lmsf_pkg::addr_type'(1);
            if (clr_cnt_ff == lmsf_pkg::addr_type'(lmsf_pkg::MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               tap_in   = '0;
               idx_in   = newest_in;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            issue.valid = 1'b1;
            tap_in      = tap_ff + lmsf_pkg::addr_type'(1);
            idx_in      = (idx_next >= taps) ? '0 : lmsf_pkg::addr_type'(idx_next);
            if (issue.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         newest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            newest_ff <= newest_in;
         end
      end
      tap_ff <= tap_in;
      idx_ff <= idx_in;
      if (accept) begin
         error_ff <= req_error_in;
         adapt_ff <= req_adapt;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff <= mac_acc;
      end
   end

   // The new sample lands in the ring at the accept edge, before any tap read.
   assign ring_we    = (state_ff == ST_CLEAR) | accept;
   assign ring_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : newest_in;
   assign ring_wdata = (state_ff == ST_CLEAR) ? '0 : req_sample_in;

   assign wgt_we    = (state_ff == ST_CLEAR) | wwr.en;
   assign wgt_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : wwr.addr;
   assign wgt_wdata = (state_ff == ST_CLEAR) ? '0 : wwr.data;

   lmsf_ram #(
      .WIDTH (lmsf_pkg::SAMPLE_W),
      .DEPTH (lmsf_pkg::MAX_TAPS)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_addr (idx_ff),
      .rd_data (ring_rdata)
   );

   lmsf_ram #(
      .WIDTH (lmsf_pkg::WEIGHT_W),
      .DEPTH (lmsf_pkg::MAX_TAPS)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wgt_we),
      .wr_addr (wgt_waddr),
      .wr_data (wgt_wdata),
      .rd_addr (tap_ff),
      .rd_data (wgt_rdata)
   );

   lmsf_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .weight_rd    (wgt_rdata),
      .sample_rd    (ring_rdata),
      .error_val    (error_ff),
      .adapt        (adapt_ff),
      .output_shift (cfg.output_shift),
      .update_shift (cfg.update_shift),
      .wwr          (wwr),
      .done         (mac_done),
      .acc          (mac_acc)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filter_out = $signed(rsp_data_ff);

endmodule
